// ----- rtl/round_robin_task_scheduler_unit_macros.svh -----
// Assertion helpers used by the scheduler controller RTL.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define RRTS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the cycle after.
`define RRTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rrts_pkg.sv -----
package rrts_pkg;

   // Table geometry
   localparam int MAX_TASKS   = 8;
   localparam int STACK_WORDS = 256;
   localparam int FRAME_WORDS = 31;

   localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W  = $clog2(MAX_TASKS + 1);
   localparam int ID_W   = 3;

   // Operation codes
   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_SCHED  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FAIL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef logic [SLOT_W-1:0] slot_idx_type;

   typedef enum logic [1:0] {
      SLOT_UNUSED  = 2'd0,
      SLOT_READY   = 2'd1,
      SLOT_RUNNING = 2'd2
   } slot_state_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_DECODE,
      FSM_SEARCH,
      FSM_LINK,
      FSM_WALK,
      FSM_RESUME,
      FSM_REPLY
   } fsm_state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] entry_addr;
      logic [31:0] saved_sp;
   } req_type;

   typedef struct packed {
      logic [1:0]      status;
      logic [ID_W-1:0] task_id;
      logic [31:0]     resume_sp;
   } rsp_type;

   // Write commands from the sequencer into the slot table
   typedef struct packed {
      logic           clear;
      logic           state_we;
      slot_idx_type   state_idx;
      slot_state_type state_val;
      logic           sp_we;
      slot_idx_type   sp_idx;
      logic [31:0]    sp_val;
      logic           ring_a_we;
      slot_idx_type   ring_a_idx;
      slot_idx_type   ring_a_val;
      logic           ring_b_we;
      slot_idx_type   ring_b_idx;
      slot_idx_type   ring_b_val;
   } tbl_wr_type;

   // One probed slot entry
   typedef struct packed {
      slot_state_type state;
      slot_idx_type   next;
      logic [31:0]    sp;
   } tbl_rd_type;

   function automatic logic [ID_W-1:0] to_id(input slot_idx_type slot);
      return ID_W'(slot);
   endfunction

   // Byte offset of a slot's initial frame from the stack region base
   function automatic logic [31:0] frame_offset(input slot_idx_type slot);
      logic [31:0] words;
      words = (32'(slot) + 32'd1) * 32'(STACK_WORDS);
      words = words - 32'(FRAME_WORDS);
      return words << 2;
   endfunction

endpackage

// ----- rtl/rrts_table.sv -----
module rrts_table
   import rrts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  tbl_wr_type   tbl_wr,
   input  slot_idx_type probe_idx,
   output tbl_rd_type   probe
);

   slot_state_type state_ff [MAX_TASKS];
   slot_state_type state_in [MAX_TASKS];
   slot_idx_type   ring_ff  [MAX_TASKS];
   slot_idx_type   ring_in  [MAX_TASKS];
   logic [31:0]    sp_ff    [MAX_TASKS];
   logic [31:0]    sp_in    [MAX_TASKS];

   // Per-entry write decode
   always_comb begin
      for (int i = 0; i < MAX_TASKS; i++) begin
         state_in[i] = state_ff[i];
         ring_in[i]  = ring_ff[i];
         sp_in[i]    = sp_ff[i];
         if (tbl_wr.clear) begin
            state_in[i] = SLOT_UNUSED;
         end else if (tbl_wr.state_we && tbl_wr.state_idx == SLOT_W'(i)) begin
            state_in[i] = tbl_wr.state_val;
         end
         if (tbl_wr.ring_a_we && tbl_wr.ring_a_idx == SLOT_W'(i)) begin
            ring_in[i] = tbl_wr.ring_a_val;
         end
         if (tbl_wr.ring_b_we && tbl_wr.ring_b_idx == SLOT_W'(i)) begin
            ring_in[i] = tbl_wr.ring_b_val;
         end
         if (tbl_wr.sp_we && tbl_wr.sp_idx == SLOT_W'(i)) begin
            sp_in[i] = tbl_wr.sp_val;
         end
      end
   end

   // Slot states reset to unused; links and pointers are written before use
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (reset) begin
            state_ff[i] <= SLOT_UNUSED;
         end else begin
            state_ff[i] <= state_in[i];
         end
         ring_ff[i] <= ring_in[i];
         sp_ff[i]   <= sp_in[i];
      end
   end

   // Single probe port
   always_comb begin
      probe.state = state_ff[probe_idx];
      probe.next  = ring_ff[probe_idx];
      probe.sp    = sp_ff[probe_idx];
   end

endmodule

// ----- rtl/rrts_ctrl.sv -----
`include "round_robin_task_scheduler_unit_macros.svh"

module rrts_ctrl
   import rrts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_type      req_data,
   output logic         req_stall,
   input  logic [31:0]  stack_base,
   input  logic         out_free,
   output logic         out_load,
   output rsp_type      out_data,
   output slot_idx_type probe_idx,
   input  tbl_rd_type   probe,
   output tbl_wr_type   tbl_wr
);

   fsm_state_type      state_ff, state_in;
   req_type            req_ff, req_in;
   slot_idx_type       ptr_ff, ptr_in;
   slot_idx_type       slot_ff, slot_in;
   slot_idx_type       cur_ff, cur_in;
   logic [CNT_W-1:0]   tries_ff, tries_in;
   logic [CNT_W-1:0]   tc_ff, tc_in;
   logic               started_ff, started_in;
   rsp_type            result_ff, result_in;
   logic [31:0]        frame;

   assign frame = stack_base + frame_offset(slot_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) state_in = FSM_DECODE;
         end
         FSM_DECODE: begin
            case (req_ff.op)
               OP_CREATE: begin
                  if (tc_ff >= CNT_W'(MAX_TASKS) || req_ff.entry_addr == '0) begin
                     state_in = FSM_REPLY;
                  end else begin
                     state_in = FSM_SEARCH;
                  end
               end
               OP_SCHED: begin
                  if (tc_ff == '0 || !started_ff) begin
                     state_in = FSM_REPLY;
                  end else begin
                     state_in = FSM_WALK;
                  end
               end
               default: state_in = FSM_REPLY;
            endcase
         end
         FSM_SEARCH: begin
            if (probe.state == SLOT_UNUSED) begin
               state_in = FSM_LINK;
            end else if (ptr_ff == SLOT_W'(MAX_TASKS - 1)) begin
               state_in = FSM_REPLY;
            end
         end
         FSM_LINK: state_in = FSM_REPLY;
         FSM_WALK: begin
            if (probe.state == SLOT_READY) begin
               state_in = FSM_REPLY;
            end else if (tries_ff == CNT_W'(MAX_TASKS)) begin
               state_in = FSM_RESUME;
            end
         end
         FSM_RESUME: state_in = FSM_REPLY;
         FSM_REPLY: begin
            if (out_free) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // Outputs, table writes and datapath updates
   always_comb begin
      req_stall  = (state_ff != FSM_IDLE);
      out_load   = 1'b0;
      out_data   = result_ff;
      probe_idx  = cur_ff;
      tbl_wr     = '0;
      req_in     = req_ff;
      ptr_in     = ptr_ff;
      slot_in    = slot_ff;
      cur_in     = cur_ff;
      tries_in   = tries_ff;
      tc_in      = tc_ff;
      started_in = started_ff;
      result_in  = result_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) req_in = req_data;
         end
         FSM_DECODE: begin
            result_in.status    = STATUS_FAIL;
            result_in.task_id   = '0;
            result_in.resume_sp = '0;
            case (req_ff.op)
               OP_CREATE: begin
                  ptr_in = '0;
               end
               OP_SCHED: begin
                  if (tc_ff == '0) begin
                     result_in.status    = STATUS_EMPTY;
                     result_in.resume_sp = req_ff.saved_sp;
                  end else if (!started_ff) begin
                     // First schedule only starts the current task
                     started_in          = 1'b1;
                     tbl_wr.state_we     = 1'b1;
                     tbl_wr.state_idx    = cur_ff;
                     tbl_wr.state_val    = SLOT_RUNNING;
                     result_in.status    = STATUS_OK;
                     result_in.task_id   = to_id(cur_ff);
                     result_in.resume_sp = probe.sp;
                  end else begin
                     // Save the preempted pointer and start the ring walk
                     if (probe.state == SLOT_RUNNING) begin
                        tbl_wr.sp_we     = 1'b1;
                        tbl_wr.sp_idx    = cur_ff;
                        tbl_wr.sp_val    = req_ff.saved_sp;
                        tbl_wr.state_we  = 1'b1;
                        tbl_wr.state_idx = cur_ff;
                        tbl_wr.state_val = SLOT_READY;
                     end
                     ptr_in   = probe.next;
                     tries_in = '0;
                  end
               end
               OP_CLEAR: begin
                  tbl_wr.clear     = 1'b1;
                  tc_in            = '0;
                  cur_in           = '0;
                  started_in       = 1'b0;
                  result_in.status = STATUS_OK;
               end
               default: ;
            endcase
         end
         FSM_SEARCH: begin
            // Lowest unused slot, one per cycle
            probe_idx = ptr_ff;
            if (probe.state == SLOT_UNUSED) begin
               slot_in = ptr_ff;
            end else if (ptr_ff != SLOT_W'(MAX_TASKS - 1)) begin
               ptr_in = ptr_ff + SLOT_W'(1);
            end
         end
         FSM_LINK: begin
            // Insert the new slot right after the current one
            tbl_wr.state_we  = 1'b1;
            tbl_wr.state_idx = slot_ff;
            tbl_wr.state_val = SLOT_READY;
            tbl_wr.sp_we     = 1'b1;
            tbl_wr.sp_idx    = slot_ff;
            tbl_wr.sp_val    = frame;
            tbl_wr.ring_a_we  = 1'b1;
            tbl_wr.ring_a_idx = slot_ff;
            if (tc_ff == '0) begin
               tbl_wr.ring_a_val = slot_ff;
               cur_in            = slot_ff;
            end else begin
               tbl_wr.ring_a_val = probe.next;
               tbl_wr.ring_b_we  = 1'b1;
               tbl_wr.ring_b_idx = cur_ff;
               tbl_wr.ring_b_val = slot_ff;
            end
            tc_in               = tc_ff + CNT_W'(1);
            result_in.status    = STATUS_OK;
            result_in.task_id   = to_id(slot_ff);
            result_in.resume_sp = frame;
         end
         FSM_WALK: begin
            // Follow ring links until a ready slot turns up
            probe_idx = ptr_ff;
            if (probe.state == SLOT_READY) begin
               cur_in              = ptr_ff;
               tbl_wr.state_we     = 1'b1;
               tbl_wr.state_idx    = ptr_ff;
               tbl_wr.state_val    = SLOT_RUNNING;
               result_in.status    = STATUS_OK;
               result_in.task_id   = to_id(ptr_ff);
               result_in.resume_sp = probe.sp;
            end else if (tries_ff != CNT_W'(MAX_TASKS)) begin
               ptr_in   = probe.next;
               tries_in = tries_ff + CNT_W'(1);
            end
         end
         FSM_RESUME: begin
            // No other ready slot: current task keeps running
            tbl_wr.state_we     = 1'b1;
            tbl_wr.state_idx    = cur_ff;
            tbl_wr.state_val    = SLOT_RUNNING;
            result_in.status    = STATUS_OK;
            result_in.task_id   = to_id(cur_ff);
            result_in.resume_sp = probe.sp;
         end
         FSM_REPLY: begin
            out_load = out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FSM_IDLE;
         cur_ff     <= '0;
         tc_ff      <= '0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cur_ff     <= cur_in;
         tc_ff      <= tc_in;
         started_ff <= started_in;
      end
      req_ff    <= req_in;
      ptr_ff    <= ptr_in;
      slot_ff   <= slot_in;
      tries_ff  <= tries_in;
      result_ff <= result_in;
   end

   // Checks
   `RRTS_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, tc_ff <= CNT_W'(MAX_TASKS), "task count over table size")
   `RRTS_ASSERT_SAME(a_started_has_task, clock, reset, started_ff, tc_ff != '0, "started with empty table")
   `RRTS_ASSERT_SAME(a_walk_bound, clock, reset, state_ff == FSM_WALK, tries_ff <= CNT_W'(MAX_TASKS), "ring walk overran")
   `RRTS_ASSERT_NEXT(a_idle_hold, clock, reset, state_ff == FSM_IDLE && !req_valid, state_ff == FSM_IDLE, "left idle without a transaction")

endmodule

// ----- rtl/round_robin_task_scheduler_unit.sv -----
// Clear, unused op, failed create and schedule without a walk reply straight from decode.
// Create searches from slot 0 for the lowest free slot, then links it into the ring.
// Schedule with a ring walk follows ring links until a ready slot turns up, and the
// current task resumes when no other slot is ready.
// One transaction at a time: req_stall stays high until the unit is back in idle; the
// ring walk and the free-slot search step one table entry per cycle through a single probe port.
// Reset (synchronous, active high): table empty, stack base 0, no result pending.
module round_robin_task_scheduler_unit
   import rrts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic [31:0]  stack_base_ff, stack_base_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;
   logic         out_free;
   logic         out_load;
   rsp_type      out_data;
   slot_idx_type probe_idx;
   tbl_rd_type   probe;
   tbl_wr_type   tbl_wr;

   // Stack region base register
   assign csr_ready     = 1'b1;
   assign stack_base_in = (csr_valid && csr_ready) ? csr_data : stack_base_ff;

   // Output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = out_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_base_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         stack_base_ff <= stack_base_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   rrts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .stack_base (stack_base_ff),
      .out_free   (out_free),
      .out_load   (out_load),
      .out_data   (out_data),
      .probe_idx  (probe_idx),
      .probe      (probe),
      .tbl_wr     (tbl_wr)
   );

   rrts_table u_table (
      .clock     (clock),
      .reset     (reset),
      .tbl_wr    (tbl_wr),
      .probe_idx (probe_idx),
      .probe     (probe)
   );

endmodule

// ----- sim/tb.sv -----
module tb;
   import rrts_pkg::*;

   // Reserved op code: no operation, answered with a failure status
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 325;
   localparam int MAX_REPORTS = 10;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data  = '0;

   round_robin_task_scheduler_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Scheduler state mirror used to work out each expected response
   slot_state_type slot_st    [MAX_TASKS];
   int unsigned    slot_link  [MAX_TASKS];
   logic [31:0]    slot_stack [MAX_TASKS];
   int unsigned    running_slot;
   int unsigned    live_tasks;
   bit             ring_started;
   logic [31:0]    stack_base;

   rsp_type     pending_rsps[$];
   rsp_type     oldest_rsp;
   int unsigned mismatch_count = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned rsp_stall_pct  = 0;

   // One row of the directed table; typed rows carry a hand-written answer
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } directed_row_type;

   directed_row_type directed_rows[$];

   function automatic int unsigned wrap_slot(input int unsigned s);
      return (s < MAX_TASKS) ? s : 0;
   endfunction

   function automatic void empty_table();
      int i;
      for (i = 0; i < MAX_TASKS; i++) begin
         slot_st[i]    = SLOT_UNUSED;
         slot_link[i]  = 0;
         slot_stack[i] = '0;
      end
      running_slot = 0;
      live_tasks   = 0;
      ring_started = 1'b0;
   endfunction

   // Apply one request to the mirror and return the response it produces
   function automatic rsp_type predict_rsp(input req_type item);
      rsp_type     r;
      int          i;
      int unsigned free_slot;
      int unsigned cur;
      int unsigned nxt;
      int unsigned hops;
      bit          found;
      r = '0;
      case (item.op)
         OP_CREATE: begin
            found     = 1'b0;
            free_slot = 0;
            if (live_tasks < MAX_TASKS && item.entry_addr != 0) begin
               for (i = 0; i < MAX_TASKS; i++) begin
                  if (!found && slot_st[i] == SLOT_UNUSED) begin
                     free_slot = i;
                     found     = 1'b1;
                  end
               end
            end
            if (!found) begin
               r.status = STATUS_FAIL;
            end else begin
               slot_st[free_slot] = SLOT_READY;
               if (live_tasks == 0) begin
                  slot_link[free_slot] = free_slot;
                  running_slot         = free_slot;
               end else begin
                  cur                  = wrap_slot(running_slot);
                  slot_link[free_slot] = wrap_slot(slot_link[cur]);
                  slot_link[cur]       = free_slot;
               end
               slot_stack[free_slot] = stack_base +
                  32'(((free_slot + 1) * STACK_WORDS - FRAME_WORDS) * 4);
               live_tasks++;
               r.status    = STATUS_OK;
               r.task_id   = free_slot[ID_W-1:0];
               r.resume_sp = slot_stack[free_slot];
            end
         end
         OP_SCHED: begin
            cur = wrap_slot(running_slot);
            if (live_tasks == 0) begin
               r.status    = STATUS_EMPTY;
               r.resume_sp = item.saved_sp;
            end else if (!ring_started) begin
               // first tick only starts the current task
               ring_started = 1'b1;
               slot_st[cur] = SLOT_RUNNING;
               r.task_id    = cur[ID_W-1:0];
               r.resume_sp  = slot_stack[cur];
            end else begin
               if (slot_st[cur] == SLOT_RUNNING) begin
                  slot_stack[cur] = item.saved_sp;
                  slot_st[cur]    = SLOT_READY;
               end
               nxt  = wrap_slot(slot_link[cur]);
               hops = 0;
               while (slot_st[nxt] != SLOT_READY && hops < MAX_TASKS) begin
                  nxt = wrap_slot(slot_link[nxt]);
                  hops++;
               end
               // nothing else ready: the current task keeps running
               if (slot_st[nxt] != SLOT_READY)
                  nxt = cur;
               running_slot = nxt;
               slot_st[nxt] = SLOT_RUNNING;
               r.task_id    = nxt[ID_W-1:0];
               r.resume_sp  = slot_stack[nxt];
            end
         end
         OP_CLEAR: begin
            empty_table();
         end
         default: begin
            r.status = STATUS_FAIL;
         end
      endcase
      return r;
   endfunction

   task automatic add_directed(input logic [1:0] op, input logic [31:0] entry,
                               input logic [31:0] sp, input bit typed,
                               input logic [1:0] status, input logic [ID_W-1:0] id,
                               input logic [31:0] want_sp);
      directed_row_type row;
      row.req.op         = op;
      row.req.entry_addr = entry;
      row.req.saved_sp   = sp;
      row.typed          = typed;
      row.want.status    = status;
      row.want.task_id   = id;
      row.want.resume_sp = want_sp;
      directed_rows.push_back(row);
   endtask

   function automatic req_type random_req();
      req_type     r;
      int unsigned roll;
      r.entry_addr = $urandom;
      r.saved_sp   = $urandom;
      if ($urandom_range(9) == 0)
         r.saved_sp = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      roll = $urandom_range(99);
      if (roll < 38) begin
         r.op = OP_CREATE;
         if (r.entry_addr == 0)
            r.entry_addr = 32'h1;
      end else if (roll < 88) begin
         r.op = OP_SCHED;
      end else if (roll < 92) begin
         r.op = OP_CLEAR;
      end else if (roll < 96) begin
         r.op         = OP_CREATE;
         r.entry_addr = '0;
      end else begin
         r.op = OP_UNUSED;
      end
      return r;
   endfunction

   // Send one request transaction and record its expected response
   task automatic issue(input req_type item, input bit use_want, input rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predicted = predict_rsp(item);
      pending_rsps.push_back(use_want ? want : predicted);
   endtask

   // Wait until every response is back and the unit has gone quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_base(input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      stack_base = value;
   endtask

   // Response side: random stall, compare each accepted transaction
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response: status %0d id %0d sp %h",
                        rsp_data.status, rsp_data.task_id, rsp_data.resume_sp);
         end else begin
            oldest_rsp = pending_rsps.pop_front();
            if (rsp_data.status !== oldest_rsp.status ||
                rsp_data.task_id !== oldest_rsp.task_id ||
                rsp_data.resume_sp !== oldest_rsp.resume_sp) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected status %0d id %0d sp %h, got %0d %0d %h",
                           oldest_rsp.status, oldest_rsp.task_id, oldest_rsp.resume_sp,
                           rsp_data.status, rsp_data.task_id, rsp_data.resume_sp);
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int          phase;
      int          n;
      int unsigned idle_mix [4];
      int unsigned stall_mix[4];
      logic [31:0] base_mix [4];
      rsp_type     none;

      none         = '0;
      idle_mix     = '{0, 84, 0, 30};
      stall_mix    = '{0, 0, 84, 30};
      base_mix[0]  = 32'hFFFF_FFFC;
      base_mix[1]  = 32'hFFFF_FFFF;
      base_mix[2]  = $urandom;
      base_mix[3]  = 32'h0000_0000;

      stack_base = '0;
      empty_table();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed table: empty table, rejects, fill to full, rotation, clear
      add_directed(OP_SCHED,  32'h0,         32'hFFFF_FFFF, 1, STATUS_EMPTY, 0, 32'hFFFF_FFFF);
      add_directed(OP_CREATE, 32'h0,         32'h0,         1, STATUS_FAIL,  0, 32'h0);
      add_directed(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, STATUS_FAIL,  0, 32'h0);
      add_directed(OP_CLEAR,  32'h0,         32'h0,         1, STATUS_OK,    0, 32'h0);
      add_directed(OP_CREATE, 32'hFFFF_FFFF, 32'h0,         1, STATUS_OK,    0, 32'h0000_0384);
      add_directed(OP_SCHED,  32'h0,         32'h1234_5678, 0, STATUS_OK,    0, 32'h0);
      add_directed(OP_SCHED,  32'h0,         32'hAAAA_AAAA, 0, STATUS_OK,    0, 32'h0);
      add_directed(OP_CREATE, 32'h0000_0001, 32'h0,         0, STATUS_OK,    0, 32'h0);
      add_directed(OP_CREATE, 32'h8000_0000, 32'h0,         0, STATUS_OK,    0, 32'h0);
      add_directed(OP_CREATE, 32'h5555_5555, 32'h0,         0, STATUS_OK,    0, 32'h0);
      add_directed(OP_CREATE, 32'hAAAA_AAAA, 32'h0,         0, STATUS_OK,    0, 32'h0);
      add_directed(OP_CREATE, 32'h7FFF_FFFF, 32'h0,         0, STATUS_OK,    0, 32'h0);
      add_directed(OP_CREATE, 32'hFFFF_FFFE, 32'h0,         0, STATUS_OK,    0, 32'h0);
      add_directed(OP_CREATE, 32'h0001_0000, 32'h0,         0, STATUS_OK,    0, 32'h0);
      add_directed(OP_CREATE, 32'h0000_0004, 32'h0,         1, STATUS_FAIL,  0, 32'h0);
      add_directed(OP_SCHED,  32'h0,         32'h0,         0, STATUS_OK,    0, 32'h0);
      add_directed(OP_SCHED,  32'h0,         32'hFFFF_FFFF, 0, STATUS_OK,    0, 32'h0);
      add_directed(OP_SCHED,  32'h0,         32'h5555_5555, 0, STATUS_OK,    0, 32'h0);
      add_directed(OP_SCHED,  32'h0,         32'hAAAA_AAAA, 0, STATUS_OK,    0, 32'h0);
      add_directed(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, STATUS_OK,    0, 32'h0);
      add_directed(OP_SCHED,  32'h0,         32'hDEAD_BEEF, 1, STATUS_EMPTY, 0, 32'hDEAD_BEEF);
      add_directed(OP_CREATE, 32'h0000_0010, 32'h0,         1, STATUS_OK,    0, 32'h0000_0384);
      add_directed(OP_CREATE, 32'h0000_0020, 32'h0,         1, STATUS_OK,    1, 32'h0000_0784);
      add_directed(OP_SCHED,  32'h0,         32'h0000_1000, 0, STATUS_OK,    0, 32'h0);
      add_directed(OP_SCHED,  32'h0,         32'h0000_2000, 0, STATUS_OK,    0, 32'h0);

      foreach (directed_rows[k])
         issue(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
      drain();

      // Random phases, each with its own stack base and idle/stall mix
      for (phase = 0; phase < 4; phase++) begin
         write_base(base_mix[phase]);
         send_idle_pct = idle_mix[phase];
         rsp_stall_pct = stall_mix[phase];
         for (n = 0; n < PHASE_ITEMS; n++)
            issue(random_req(), 1'b0, none);
         rsp_stall_pct = 0;
         drain();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- round_robin_task_scheduler_unit.f -----
+incdir+rtl
rtl/rrts_pkg.sv
rtl/rrts_table.sv
rtl/rrts_ctrl.sv
rtl/round_robin_task_scheduler_unit.sv
sim/tb.sv
